FILE: hdl/usr_pkg.sv
// ----------------------------------------------------------------------------
// usr_pkg
// Shared types, codes and descriptor tables for the endpoint-0 request
// responder.
// ----------------------------------------------------------------------------
package usr_pkg;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_DATA       = 3'd1,
        ACT_ZLP        = 3'd2,
        ACT_ACK_IN     = 3'd3,
        ACT_STALL      = 3'd4,
        ACT_STATUS_OUT = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        KIND_DEVICE = 3'd0,
        KIND_CONFIG = 3'd1,
        KIND_STR0   = 3'd2,
        KIND_STR1   = 3'd3,
        KIND_STR2   = 3'd4,
        KIND_STR3   = 3'd5,
        KIND_EMPTY  = 3'd6
    } kind_t;

    localparam logic [1:0] DS_POWERED    = 2'd0;
    localparam logic [1:0] DS_DEFAULT    = 2'd1;
    localparam logic [1:0] DS_ADDRESSED  = 2'd2;
    localparam logic [1:0] DS_CONFIGURED = 2'd3;

    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    localparam logic [15:0] MAX_ADDR = 16'h007F;

    localparam logic [1:0] CFG_VENDOR_ID  = 2'd0;
    localparam logic [1:0] CFG_PRODUCT_ID = 2'd1;
    localparam logic [1:0] CFG_SERIAL     = 2'd2;

    localparam logic [15:0] VENDOR_ID_RST  = 16'd9049;
    localparam logic [15:0] PRODUCT_ID_RST = 16'd6021;
    localparam logic [23:0] SERIAL_RST     = 24'h123456;

    // Count of bytes in one descriptor is at most 48.
    localparam int CNT_W = 6;

    // Decision taken for one accepted request.
    typedef struct packed {
        logic [1:0]       dev_state;
        logic [6:0]       dev_addr;
        action_t          action;
        logic             desc;
        kind_t            kind;
        logic [CNT_W-1:0] count;
    } ch9_dec_t;

    function automatic logic [CNT_W-1:0] desc_len(input kind_t kind);
        logic [CNT_W-1:0] n;
        case (kind)
            KIND_DEVICE: n = 6'd18;
            KIND_CONFIG: n = 6'd32;
            KIND_STR0:   n = 6'd4;
            KIND_STR1:   n = 6'd48;
            KIND_STR2:   n = 6'd36;
            KIND_STR3:   n = 6'd14;
            default:     n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] conf_byte(input logic [4:0] i);
        logic [7:0] b;
        case (i)
            5'd0:  b = 8'h09;  5'd1:  b = 8'h02;  5'd2:  b = 8'h20;  5'd3:  b = 8'h00;
            5'd4:  b = 8'h01;  5'd5:  b = 8'h01;  5'd6:  b = 8'h04;  5'd7:  b = 8'hC0;
            5'd8:  b = 8'h32;  5'd9:  b = 8'h09;  5'd10: b = 8'h04;  5'd11: b = 8'h00;
            5'd12: b = 8'h00;  5'd13: b = 8'h02;  5'd14: b = 8'hFF;  5'd15: b = 8'hFF;
            5'd16: b = 8'h01;  5'd17: b = 8'h05;  5'd18: b = 8'h07;  5'd19: b = 8'h05;
            5'd20: b = 8'h01;  5'd21: b = 8'h02;  5'd22: b = 8'h00;  5'd23: b = 8'h02;
            5'd24: b = 8'h00;  5'd25: b = 8'h07;  5'd26: b = 8'h05;  5'd27: b = 8'h82;
            5'd28: b = 8'h02;  5'd29: b = 8'h00;  5'd30: b = 8'h02;  5'd31: b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] lang_byte(input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = 8'h04;
            2'd1:    b = 8'h03;
            2'd2:    b = 8'h09;
            default: b = 8'h04;
        endcase
        return b;
    endfunction

    // Characters of the manufacturer string; zero past the end.
    function automatic logic [7:0] maker_char(input logic [4:0] c);
        logic [7:0] b;
        case (c)
            5'd0:  b = 8'h4F;  5'd1:  b = 8'h6E;  5'd2:  b = 8'h79;  5'd3:  b = 8'h78;
            5'd4:  b = 8'h20;  5'd5:  b = 8'h49;  5'd6:  b = 8'h6E;  5'd7:  b = 8'h74;
            5'd8:  b = 8'h65;  5'd9:  b = 8'h72;  5'd10: b = 8'h6E;  5'd11: b = 8'h61;
            5'd12: b = 8'h74;  5'd13: b = 8'h69;  5'd14: b = 8'h6F;  5'd15: b = 8'h6E;
            5'd16: b = 8'h61;  5'd17: b = 8'h6C;  5'd18: b = 8'h20;  5'd19: b = 8'h49;
            5'd20: b = 8'h6E;  5'd21: b = 8'h63;  5'd22: b = 8'h2E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Characters of the product string; zero past the end.
    function automatic logic [7:0] prod_char(input logic [4:0] c);
        logic [7:0] b;
        case (c)
            5'd0:  b = 8'h4F;  5'd1:  b = 8'h6E;  5'd2:  b = 8'h79;  5'd3:  b = 8'h78;
            5'd4:  b = 8'h20;  5'd5:  b = 8'h42;  5'd6:  b = 8'h4F;  5'd7:  b = 8'h4F;
            5'd8:  b = 8'h58;  5'd9:  b = 8'h20;  5'd10: b = 8'h65;  5'd11: b = 8'h72;
            5'd12: b = 8'h65;  5'd13: b = 8'h61;  5'd14: b = 8'h64;  5'd15: b = 8'h65;
            5'd16: b = 8'h72;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/usb_standard_request_responder.sv
// ----------------------------------------------------------------------------
// usb_standard_request_responder
// Endpoint-0 responder for USB standard requests.
// ----------------------------------------------------------------------------
// Each input transfer is a bus reset (tuser high) or a decoded setup packet.
// Resets, address and configuration requests and ignored requests give one
// result, registered at the edge that accepts the item. GET_DESCRIPTOR gives
// one data byte per cycle while the output slot is free, or a zero-length
// result when nothing is to be sent, followed by an expect-status-out result.
// The byte counter of the sequencer steps once per delivered data byte, and
// output back-pressure stalls the sequence. Every result carries the device
// address and state after the request, and tlast marks the final result of
// an item. s_tready is low until that final result has been taken or is
// being taken. Configuration writes take effect at once and must be made
// while the block is idle.
module usb_standard_request_responder
    import usr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] request_code, [23:8] request_value, [39:24] request_index,
    // [55:40] request_length
    input  logic [55:0] s_tdata,
    // [0] req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] action, [10:3] data_byte, [17:11] device_address,
    // [19:18] device_state, [23:20] zero
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ZLP,
        SEQ_DATA,
        SEQ_TAIL
    } seq_t;

    seq_t             seq_reg, seq_next;
    logic [1:0]       dev_state_reg, dev_state_next;
    logic [6:0]       dev_addr_reg, dev_addr_next;
    kind_t            kind_reg, kind_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] num_reg, num_next;
    logic             m_tvalid_reg, m_tvalid_next;
    action_t          m_action_reg, m_action_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;
    logic [15:0]      vendor_id_reg;
    logic [15:0]      product_id_reg;
    logic [23:0]      serial_reg;

    ch9_dec_t         dec;
    logic [7:0]       rom_byte;
    logic [CNT_W-1:0] cnt_inc;
    logic             slot_free;
    logic             s_fire;

    usr_ch9 u_ch9 (
        .req_type       (s_tuser),
        .request_code   (s_tdata[7:0]),
        .request_value  (s_tdata[23:8]),
        .request_index  (s_tdata[39:24]),
        .request_length (s_tdata[55:40]),
        .dev_state      (dev_state_reg),
        .dev_addr       (dev_addr_reg),
        .dec            (dec)
    );

    usr_desc_rom u_rom (
        .kind          (kind_reg),
        .idx           (cnt_reg),
        .vendor_id     (vendor_id_reg),
        .product_id    (product_id_reg),
        .serial_digits (serial_reg),
        .data_byte     (rom_byte)
    );

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (seq_reg == SEQ_IDLE) && slot_free;
    assign s_fire    = s_tvalid && s_tready;
    assign cnt_inc   = cnt_reg + 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, dev_state_reg, dev_addr_reg, m_byte_reg, m_action_reg};

    always_comb begin
        seq_next       = seq_reg;
        dev_state_next = dev_state_reg;
        dev_addr_next  = dev_addr_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_action_next  = m_action_reg;
        m_byte_next    = m_byte_reg;
        m_last_next    = m_last_reg;
        case (seq_reg)
            SEQ_IDLE: begin
                if (s_fire) begin
                    dev_state_next = dec.dev_state;
                    dev_addr_next  = dec.dev_addr;
                    if (dec.desc) begin
                        kind_next = dec.kind;
                        num_next  = dec.count;
                        cnt_next  = '0;
                        seq_next  = (dec.count == '0) ? SEQ_ZLP : SEQ_DATA;
                    end else begin
                        m_tvalid_next = 1'b1;
                        m_action_next = dec.action;
                        m_byte_next   = 8'd0;
                        m_last_next   = 1'b1;
                    end
                end
            end
            SEQ_ZLP: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_action_next = ACT_ZLP;
                    m_byte_next   = 8'd0;
                    m_last_next   = 1'b0;
                    seq_next      = SEQ_TAIL;
                end
            end
            SEQ_DATA: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_action_next = ACT_DATA;
                    m_byte_next   = rom_byte;
                    m_last_next   = 1'b0;
                    cnt_next      = cnt_inc;
                    if (cnt_inc == num_reg) begin
                        seq_next = SEQ_TAIL;
                    end
                end
            end
            SEQ_TAIL: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_action_next = ACT_STATUS_OUT;
                    m_byte_next   = 8'd0;
                    m_last_next   = 1'b1;
                    seq_next      = SEQ_IDLE;
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= SEQ_IDLE;
            dev_state_reg <= DS_POWERED;
            dev_addr_reg  <= 7'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            seq_reg       <= seq_next;
            dev_state_reg <= dev_state_next;
            dev_addr_reg  <= dev_addr_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        kind_reg     <= kind_next;
        cnt_reg      <= cnt_next;
        num_reg      <= num_next;
        m_action_reg <= m_action_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vendor_id_reg  <= VENDOR_ID_RST;
            product_id_reg <= PRODUCT_ID_RST;
            serial_reg     <= SERIAL_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_VENDOR_ID:  vendor_id_reg  <= cfg_wdata[15:0];
                CFG_PRODUCT_ID: product_id_reg <= cfg_wdata[15:0];
                CFG_SERIAL:     serial_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/usr_ch9.sv
// ----------------------------------------------------------------------------
// usr_ch9
// Device state rules: decides the response to a bus reset or a setup packet
// and the device state and address that follow it.
// ----------------------------------------------------------------------------
module usr_ch9
    import usr_pkg::*;
(
    input  logic        req_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_index,
    input  logic [15:0] request_length,
    input  logic [1:0]  dev_state,
    input  logic [6:0]  dev_addr,
    output ch9_dec_t    dec
);

    logic [7:0]       cfg_val;
    logic [7:0]       str_idx;
    logic [CNT_W-1:0] full_len;

    assign cfg_val  = request_value[7:0];
    assign str_idx  = request_value[7:0];

    always_comb begin
        dec.dev_state = dev_state;
        dec.dev_addr  = dev_addr;
        dec.action    = ACT_NONE;
        dec.desc      = 1'b0;
        dec.kind      = KIND_DEVICE;
        if (req_type) begin
            dec.dev_state = DS_DEFAULT;
            dec.dev_addr  = 7'd0;
        end else begin
            case (request_code)
                REQ_SET_ADDRESS: begin
                    if (request_index == 16'd0 && request_length == 16'd0
                        && request_value <= MAX_ADDR) begin
                        case (dev_state)
                            DS_DEFAULT: begin
                                dec.action = ACT_ACK_IN;
                                if (request_value != 16'd0) begin
                                    dec.dev_addr  = request_value[6:0];
                                    dec.dev_state = DS_ADDRESSED;
                                end
                            end
                            DS_ADDRESSED: begin
                                dec.action   = ACT_ACK_IN;
                                dec.dev_addr = request_value[6:0];
                                if (request_value == 16'd0) begin
                                    dec.dev_state = DS_DEFAULT;
                                end
                            end
                            DS_CONFIGURED: begin
                                if (request_value == 16'd0) begin
                                    dec.action    = ACT_ACK_IN;
                                    dec.dev_addr  = 7'd0;
                                    dec.dev_state = DS_DEFAULT;
                                end else begin
                                    dec.action = ACT_STALL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                REQ_SET_CONFIG: begin
                    if (dev_state == DS_ADDRESSED) begin
                        if (cfg_val == 8'd0) begin
                            dec.action = ACT_ACK_IN;
                        end else if (cfg_val == 8'd1) begin
                            dec.action    = ACT_ACK_IN;
                            dec.dev_state = DS_CONFIGURED;
                        end
                    end else if (dev_state == DS_CONFIGURED) begin
                        dec.action = ACT_ACK_IN;
                        if (cfg_val == 8'd0) begin
                            dec.dev_state = DS_ADDRESSED;
                        end
                    end else begin
                        dec.action = ACT_STALL;
                    end
                end
                REQ_GET_DESCRIPTOR: begin
                    case (request_value[15:8])
                        DT_DEVICE: begin
                            dec.desc = 1'b1;
                            dec.kind = KIND_DEVICE;
                        end
                        DT_CONFIG: begin
                            dec.desc = 1'b1;
                            dec.kind = KIND_CONFIG;
                        end
                        DT_STRING: begin
                            dec.desc = 1'b1;
                            case (str_idx)
                                8'd0:    dec.kind = KIND_STR0;
                                8'd1:    dec.kind = KIND_STR1;
                                8'd2:    dec.kind = KIND_STR2;
                                8'd3:    dec.kind = KIND_STR3;
                                default: dec.kind = KIND_EMPTY;
                            endcase
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // The reply is clamped to what the host asked for.
        full_len  = desc_len(dec.kind);
        dec.count = (request_length < {{(16-CNT_W){1'b0}}, full_len})
                    ? request_length[CNT_W-1:0] : full_len;
    end

endmodule

FILE: hdl/usr_desc_rom.sv
// ----------------------------------------------------------------------------
// usr_desc_rom
// Byte lookup for the device, configuration and string descriptors, with
// the identifiers and serial digits taken from the configuration registers.
// ----------------------------------------------------------------------------
module usr_desc_rom
    import usr_pkg::*;
(
    input  kind_t            kind,
    input  logic [CNT_W-1:0] idx,
    input  logic [15:0]      vendor_id,
    input  logic [15:0]      product_id,
    input  logic [23:0]      serial_digits,
    output logic [7:0]       data_byte
);

    logic [4:0] chr;
    logic [3:0] digit;
    logic [7:0] dev_byte;
    logic [7:0] str_char;
    logic [7:0] str_len;

    // String descriptors hold one UTF-16 character per byte pair after the header.
    assign chr = idx[CNT_W-1:1] - 5'd1;

    always_comb begin
        case (chr[2:0])
            3'd0:    digit = serial_digits[23:20];
            3'd1:    digit = serial_digits[19:16];
            3'd2:    digit = serial_digits[15:12];
            3'd3:    digit = serial_digits[11:8];
            3'd4:    digit = serial_digits[7:4];
            3'd5:    digit = serial_digits[3:0];
            default: digit = 4'd0;
        endcase
    end

    always_comb begin
        case (idx)
            6'd0:    dev_byte = 8'h12;
            6'd1:    dev_byte = 8'h01;
            6'd2:    dev_byte = 8'h00;
            6'd3:    dev_byte = 8'h02;
            6'd4:    dev_byte = 8'hFF;
            6'd5:    dev_byte = 8'hFF;
            6'd6:    dev_byte = 8'hFF;
            6'd7:    dev_byte = 8'h40;
            6'd8:    dev_byte = vendor_id[7:0];
            6'd9:    dev_byte = vendor_id[15:8];
            6'd10:   dev_byte = product_id[7:0];
            6'd11:   dev_byte = product_id[15:8];
            6'd12:   dev_byte = 8'h01;
            6'd13:   dev_byte = 8'h00;
            6'd14:   dev_byte = 8'h01;
            6'd15:   dev_byte = 8'h02;
            6'd16:   dev_byte = 8'h03;
            default: dev_byte = 8'h01;
        endcase
    end

    always_comb begin
        case (kind)
            KIND_STR1: begin
                str_len  = 8'd48;
                str_char = maker_char(chr);
            end
            KIND_STR2: begin
                str_len  = 8'd36;
                str_char = prod_char(chr);
            end
            default: begin
                str_len  = 8'd14;
                str_char = 8'h30 + {4'd0, digit};
            end
        endcase
    end

    always_comb begin
        case (kind)
            KIND_DEVICE: data_byte = dev_byte;
            KIND_CONFIG: data_byte = conf_byte(idx[4:0]);
            KIND_STR0:   data_byte = lang_byte(idx[1:0]);
            KIND_STR1, KIND_STR2, KIND_STR3: begin
                if (idx == 6'd0) begin
                    data_byte = str_len;
                end else if (idx == 6'd1) begin
                    data_byte = 8'h03;
                end else if (idx[0]) begin
                    data_byte = 8'h00;
                end else begin
                    data_byte = str_char;
                end
            end
            default:     data_byte = 8'h00;
        endcase
    end

endmodule

FILE: hdl/usr_checker.sv
// ----------------------------------------------------------------------------
// usr_checker
// Port-level checks for the request responder, bound to the top level.
// ----------------------------------------------------------------------------
module usr_checker
    import usr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A new request is taken only when the result slot is free.
    a_ready_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while a result is blocked");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ACT_DATA) |-> (m_tdata[10:3] == 8'd0))
        else $error("data byte set on a non-data result");

    // Addressed and configured states always have a nonzero address.
    a_addr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[19:18] == DS_ADDRESSED || m_tdata[19:18] == DS_CONFIGURED)
                      == (m_tdata[17:11] != 7'd0)))
        else $error("device address does not match device state");

    // While a reply is still running, no new request is taken.
    a_no_take_midreply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> !(s_tvalid && s_tready))
        else $error("request accepted in the middle of a reply");

endmodule

bind usb_standard_request_responder usr_checker u_usr_checker (.*);
